// ----- hdl/tlbs_pkg.sv -----
// Package for the table search block: table depth, derived widths, op codes.
// Depends on nothing; used by table_linear_binary_search.
package tlbs_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int BND_W = CNT_W + 1;
  localparam int DATA_W = 32;
  localparam int LOC_W = 7;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_LINEAR = 2'd2,
    OP_BINARY = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LSCAN = 4'b0010,
    S_BREQ  = 4'b0100,
    S_BWAIT = 4'b1000
  } state_t;

endpackage

// ----- hdl/table_linear_binary_search.sv -----
// Top level of the table search block: entry memory, linear scan and binary search.
// Depends on tlbs_pkg.
//
// channel   ports                        transfer
// command   start, op, value / busy      start high and busy low at a clock edge
// result    strobe, found, location, last strobe high for a single cycle per result
//
// Clear and append leave busy low.
// A linear search holds busy while it reads the entries in order, one memory read
// a cycle, compares each registered read with the key, then gives the final result.
// A binary search takes a read state and a compare state per halving step
// (S_BREQ, S_BWAIT) until it finds the key or the range is empty.
// Reset clears the entry count and the control state; the memory is not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
module table_linear_binary_search (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          op,
  input  logic signed [tlbs_pkg::DATA_W-1:0]  value,
  output logic                                strobe,
  output logic                                found,
  output logic [tlbs_pkg::LOC_W-1:0]          location,
  output logic                                last
);

  tlbs_pkg::state_t state;

  logic signed [tlbs_pkg::DATA_W-1:0] mem [tlbs_pkg::DEPTH];
  logic signed [tlbs_pkg::DATA_W-1:0] rd_data;
  logic signed [tlbs_pkg::DATA_W-1:0] key;
  logic [tlbs_pkg::IDX_W-1:0]         rd_addr;
  logic                               rd_en;
  logic                               wr_en;

  logic [tlbs_pkg::CNT_W-1:0] cnt;
  logic [tlbs_pkg::CNT_W-1:0] rd_idx;
  logic                       cmp_vld;
  logic [tlbs_pkg::LOC_W-1:0] cmp_loc;
  logic                       pend_vld;
  logic [tlbs_pkg::LOC_W-1:0] pend_loc;
  logic [tlbs_pkg::BND_W-1:0] low;
  logic [tlbs_pkg::BND_W-1:0] high;
  logic [tlbs_pkg::BND_W-1:0] mid;
  logic                       issue;
  logic                       accept;

  assign busy   = (state != tlbs_pkg::S_IDLE);
  assign accept = start && !busy;
  assign issue  = (state == tlbs_pkg::S_LSCAN) && (rd_idx < cnt);
  assign mid    = tlbs_pkg::BND_W'((low + high) >> 1);
  assign wr_en  = accept && (op == tlbs_pkg::OP_APPEND) &&
                  (cnt < tlbs_pkg::CNT_W'(tlbs_pkg::DEPTH));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = tlbs_pkg::IDX_W'(rd_idx);
    if (issue) begin
      rd_en = 1'b1;
    end else if ((state == tlbs_pkg::S_BREQ) && (low <= high)) begin
      rd_en   = 1'b1;
      rd_addr = tlbs_pkg::IDX_W'(mid - tlbs_pkg::BND_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tlbs_pkg::IDX_W'(cnt)] <= value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tlbs_pkg::S_IDLE;
      cnt      <= '0;
      strobe   <= 1'b0;
      cmp_vld  <= 1'b0;
      pend_vld <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        tlbs_pkg::S_IDLE: begin
          if (accept) begin
            key      <= value;
            rd_idx   <= '0;
            cmp_vld  <= 1'b0;
            pend_vld <= 1'b0;
            low      <= tlbs_pkg::BND_W'(1);
            high     <= tlbs_pkg::BND_W'(cnt);
            unique case (op)
              tlbs_pkg::OP_CLEAR:  cnt <= '0;
              tlbs_pkg::OP_APPEND: begin
                if (wr_en) begin
                  cnt <= cnt + tlbs_pkg::CNT_W'(1);
                end
              end
              tlbs_pkg::OP_LINEAR: state <= tlbs_pkg::S_LSCAN;
              tlbs_pkg::OP_BINARY: state <= tlbs_pkg::S_BREQ;
              default:             state <= tlbs_pkg::S_IDLE;
            endcase
          end
        end
        tlbs_pkg::S_LSCAN: begin
          cmp_vld <= issue;
          if (issue) begin
            rd_idx  <= rd_idx + tlbs_pkg::CNT_W'(1);
            cmp_loc <= tlbs_pkg::LOC_W'(rd_idx) + tlbs_pkg::LOC_W'(1);
          end
          if (cmp_vld && (rd_data == key)) begin
            if (pend_vld) begin
              strobe   <= 1'b1;
              found    <= 1'b1;
              location <= pend_loc;
              last     <= 1'b0;
            end
            pend_vld <= 1'b1;
            pend_loc <= cmp_loc;
          end
          if (!issue && !cmp_vld) begin
            strobe   <= 1'b1;
            found    <= pend_vld;
            location <= pend_vld ? pend_loc : '0;
            last     <= 1'b1;
            state    <= tlbs_pkg::S_IDLE;
          end
        end
        tlbs_pkg::S_BREQ: begin
          if (low <= high) begin
            state <= tlbs_pkg::S_BWAIT;
          end else begin
            strobe   <= 1'b1;
            found    <= 1'b0;
            location <= '0;
            last     <= 1'b1;
            state    <= tlbs_pkg::S_IDLE;
          end
        end
        tlbs_pkg::S_BWAIT: begin
          if (rd_data == key) begin
            strobe   <= 1'b1;
            found    <= 1'b1;
            location <= tlbs_pkg::LOC_W'(mid);
            last     <= 1'b1;
            state    <= tlbs_pkg::S_IDLE;
          end else begin
            if (key < rd_data) begin
              high <= mid - tlbs_pkg::BND_W'(1);
            end else begin
              low <= mid + tlbs_pkg::BND_W'(1);
            end
            state <= tlbs_pkg::S_BREQ;
          end
        end
        default: state <= tlbs_pkg::S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for table_linear_binary_search: clear, append, linear and binary search.
// A clocked driver feeds commands from a queue; a monitor checks every result transfer.
// Depends on tlbs_pkg and the table_linear_binary_search RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int MIN_WORD = -2147483647 - 1;
  localparam int MAX_WORD = 2147483647;
  localparam int PHASE_ITEMS = 70;
  localparam int DRAIN_CYCLES = 2 * tlbs_pkg::DEPTH + 8;

  typedef struct {
    tlbs_pkg::op_t                       op;
    logic signed [tlbs_pkg::DATA_W-1:0]  value;
  } command_t;

  typedef struct {
    logic                        found;
    logic [tlbs_pkg::LOC_W-1:0]  location;
    logic                        last;
  } hit_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 start = 1'b0;
  tlbs_pkg::op_t                        op = tlbs_pkg::OP_CLEAR;
  logic signed [tlbs_pkg::DATA_W-1:0]   value = '0;
  logic                                 busy;
  logic                                 strobe;
  logic                                 found;
  logic [tlbs_pkg::LOC_W-1:0]           location;
  logic                                 last;

  command_t                             command_q[$];
  hit_t                                 expected_hits[$];
  logic signed [tlbs_pkg::DATA_W-1:0]   table_words[tlbs_pkg::DEPTH];
  int                                   table_fill = 0;
  int                                   idle_pct = 0;
  int                                   queued_count = 0;
  int                                   error_count = 0;

  table_linear_binary_search dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .op       (op),
    .value    (value),
    .strobe   (strobe),
    .found    (found),
    .location (location),
    .last     (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic search_table(input tlbs_pkg::op_t cmd,
                              input logic signed [tlbs_pkg::DATA_W-1:0] key);
    int low, high, mid, last_hit;
    case (cmd)
      tlbs_pkg::OP_CLEAR: table_fill = 0;
      tlbs_pkg::OP_APPEND: begin
        if (table_fill < tlbs_pkg::DEPTH) begin
          table_words[table_fill] = key;
          table_fill++;
        end
      end
      tlbs_pkg::OP_LINEAR: begin
        last_hit = -1;
        for (int i = 0; i < table_fill; i++)
          if (table_words[i] == key) last_hit = i;
        if (last_hit < 0) begin
          expected_hits.push_back('{1'b0, '0, 1'b1});
        end else begin
          for (int i = 0; i <= last_hit; i++)
            if (table_words[i] == key)
              expected_hits.push_back('{1'b1, tlbs_pkg::LOC_W'(i + 1), i == last_hit});
        end
      end
      default: begin
        low = 1;
        high = table_fill;
        while (low <= high) begin
          mid = (low + high) / 2;
          if (table_words[mid - 1] == key) break;
          if (key < table_words[mid - 1]) high = mid - 1;
          else low = mid + 1;
        end
        if (low <= high) expected_hits.push_back('{1'b1, tlbs_pkg::LOC_W'(mid), 1'b1});
        else expected_hits.push_back('{1'b0, '0, 1'b1});
      end
    endcase
  endtask

  // Driver: hold a presented command until busy is low, then transfer it.
  always @(posedge clk) begin
    command_t cur;
    if (rst) begin
      start <= 1'b0;
      op <= tlbs_pkg::OP_CLEAR;
      value <= '0;
    end else if (!(start && busy)) begin
      if (start) search_table(op, value);
      if (command_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cur = command_q.pop_front();
        start <= 1'b1;
        op <= cur.op;
        value <= cur.value;
      end else begin
        start <= 1'b0;
        op <= tlbs_pkg::op_t'($urandom_range(3));
        value <= $urandom;
      end
    end
  end

  task automatic report(input string field, input int want, input int got);
    if (error_count < 40)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    error_count++;
  endtask

  // Monitor: every result transfer must match the oldest expected hit.
  always @(posedge clk) begin
    hit_t want;
    if (!rst && strobe === 1'b1) begin
      if (expected_hits.size() == 0) begin
        report("unexpected result, location", -1, location);
      end else begin
        want = expected_hits.pop_front();
        if (found !== want.found) report("found", want.found, found);
        if (location !== want.location) report("location", want.location, location);
        if (last !== want.last) report("last", want.last, last);
      end
    end
  end

  task automatic queue_cmd(input tlbs_pkg::op_t cmd, input int v);
    command_q.push_back('{cmd, v});
    queued_count++;
  endtask

  function automatic int pick_value(input int mode);
    case (mode)
      0: return int'($urandom_range(8)) - 4;
      1: return $urandom;
      default: begin
        case ($urandom_range(3))
          0: return MIN_WORD;
          1: return MAX_WORD;
          2: return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  task automatic random_sequence(input bit full);
    int vals[$];
    int n, mode, key;
    n = full ? tlbs_pkg::DEPTH + $urandom_range(1, 4) : $urandom_range(0, 12);
    mode = $urandom_range(2);
    if ($urandom_range(9) != 0) queue_cmd(tlbs_pkg::OP_CLEAR, $urandom);
    for (int i = 0; i < n; i++) vals.push_back(pick_value(mode));
    if ($urandom_range(3) != 0) vals.sort();
    foreach (vals[i]) queue_cmd(tlbs_pkg::OP_APPEND, vals[i]);
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(9) == 0) begin
        queue_cmd(tlbs_pkg::op_t'($urandom_range(3)), $urandom);
      end else begin
        if (vals.size() != 0 && $urandom_range(4) < 3) key = vals[$urandom_range(vals.size() - 1)];
        else key = pick_value(mode);
        queue_cmd($urandom_range(1) ? tlbs_pkg::OP_LINEAR : tlbs_pkg::OP_BINARY, key);
      end
    end
  endtask

  task automatic drain();
    while (command_q.size() != 0 || start || expected_hits.size() != 0) @(negedge clk);
  endtask

  initial begin
    int phase_idle[4];
    phase_idle = '{0, 46, 23, 0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    queue_cmd(tlbs_pkg::OP_LINEAR, 5);
    queue_cmd(tlbs_pkg::OP_BINARY, 5);
    queue_cmd(tlbs_pkg::OP_APPEND, MIN_WORD);
    queue_cmd(tlbs_pkg::OP_APPEND, -1);
    queue_cmd(tlbs_pkg::OP_APPEND, 0);
    queue_cmd(tlbs_pkg::OP_APPEND, 0);
    queue_cmd(tlbs_pkg::OP_APPEND, 1);
    queue_cmd(tlbs_pkg::OP_APPEND, MAX_WORD);
    queue_cmd(tlbs_pkg::OP_LINEAR, 0);
    queue_cmd(tlbs_pkg::OP_LINEAR, MAX_WORD);
    queue_cmd(tlbs_pkg::OP_LINEAR, MIN_WORD);
    queue_cmd(tlbs_pkg::OP_LINEAR, 3);
    queue_cmd(tlbs_pkg::OP_BINARY, MIN_WORD);
    queue_cmd(tlbs_pkg::OP_BINARY, MAX_WORD);
    queue_cmd(tlbs_pkg::OP_BINARY, 0);
    queue_cmd(tlbs_pkg::OP_BINARY, -1);
    queue_cmd(tlbs_pkg::OP_BINARY, 3);
    queue_cmd(tlbs_pkg::OP_CLEAR, 0);
    queue_cmd(tlbs_pkg::OP_LINEAR, 0);
    queue_cmd(tlbs_pkg::OP_BINARY, 0);
    queue_cmd(tlbs_pkg::OP_APPEND, 7);
    queue_cmd(tlbs_pkg::OP_APPEND, -7);
    queue_cmd(tlbs_pkg::OP_BINARY, -7);
    queue_cmd(tlbs_pkg::OP_LINEAR, -7);
    drain();

    foreach (phase_idle[p]) begin
      idle_pct = phase_idle[p];
      queued_count = 0;
      random_sequence(p == 0);
      while (queued_count < PHASE_ITEMS) random_sequence($urandom_range(7) == 0);
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && expected_hits.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
